// ===== rtl/core/smda_pkg.sv =====
// Shared constants and opcodes for the signed multiply/divide ALU.
`timescale 1ns / 1ps

package smda_pkg;

    // Datapath width of operands and result
    localparam int DATA_WIDTH = 32;

    // Iteration counter width: one step per operand bit
    localparam int CNT_W = $clog2(DATA_WIDTH);

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_WIDTH - 1);

    // Opcodes
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_REM = 3'd4;

    // Result returned for an unknown opcode: -11111111 wrapped to the datapath width
    localparam logic [DATA_WIDTH-1:0] BAD_OPCODE_RESULT = DATA_WIDTH'(-64'sd11111111);

    typedef logic [DATA_WIDTH-1:0] word_t;

endpackage

// ===== rtl/core/signed_mul_div_alu.sv =====
// Signed integer ALU: add, subtract, shift-add multiply, restoring divide and remainder.
//
// Usage:
//   Input channel (in_valid / in_stall) carries opcode, operand_a, operand_b.
//   An item transfers when in_valid is high and in_stall is low. The unit holds
//   in_stall high while it works on an item, so it takes one item at a time.
//   Output channel (out_valid / out_stall) carries one result per item; the
//   result sits in an output register and transfers when out_stall is low.
//   A new item is taken while an earlier result still waits in that register.
// Steps, from the input transfer to out_valid rising:
//   add, subtract, unknown opcode, divide by zero: setup, then handoff.
//   multiply: setup, multiply steps, handoff; divide and remainder: setup,
//   divisor magnitude, divide steps, sign fixup, handoff. The next input
//   transfers once the sequencer is idle again.
//   The steps use the single shared adder: one step per operand bit
//   for multiply and divide, plus magnitude and sign fixup passes for divide.
// Reset: rst_n clears the sequencer and the output valid; no item is in flight.
// Stall: a finished result waits in the sequencer until the output register
//   is free, and in_stall stays high until it has moved there.
`timescale 1ns / 1ps

module signed_mul_div_alu
    import smda_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [2:0]            opcode,
    input  logic [DATA_WIDTH-1:0] operand_a,
    input  logic [DATA_WIDTH-1:0] operand_b,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [DATA_WIDTH-1:0] result
);

    // Sequencer state codes
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_NEGB = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_FIX  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    logic [2:0]       op_reg, op_next;
    word_t            a_reg, a_next;
    word_t            b_reg, b_next;
    word_t            acc_reg, acc_next;
    word_t            result_reg, result_next;
    logic             neg_q_reg, neg_q_next;
    logic             neg_r_reg, neg_r_next;

    // Shared adder/subtractor
    word_t            add_x, add_y;
    logic             add_sub;
    logic [DATA_WIDTH:0] add_sum;
    logic             add_carry;
    word_t            rem_shift;
    logic             in_xfer, out_xfer, out_free;

    assign in_xfer   = in_valid && !in_stall;
    assign out_xfer  = out_valid_reg && !out_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign rem_shift = {acc_reg[DATA_WIDTH-2:0], a_reg[DATA_WIDTH-1]};

    assign add_sum   = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
                     + {{DATA_WIDTH{1'b0}}, add_sub};
    assign add_carry = add_sum[DATA_WIDTH];

    // Select adder operands for the current step
    always_comb
    begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        unique case (state_reg) inside
            S_PREP:
            begin
                case (op_reg) inside
                    OP_ADD:
                    begin
                        add_x = a_reg;
                        add_y = b_reg;
                    end
                    OP_SUB:
                    begin
                        add_x   = a_reg;
                        add_y   = b_reg;
                        add_sub = 1'b1;
                    end
                    default:
                    begin
                        add_y   = a_reg;
                        add_sub = 1'b1;
                    end
                endcase
            end
            S_NEGB:
            begin
                add_y   = b_reg;
                add_sub = 1'b1;
            end
            S_MUL:
            begin
                add_x = acc_reg;
                add_y = a_reg;
            end
            S_DIV:
            begin
                add_x   = rem_shift;
                add_y   = b_reg;
                add_sub = 1'b1;
            end
            S_FIX:
            begin
                add_y   = (op_reg == OP_DIV) ? a_reg : acc_reg;
                add_sub = 1'b1;
            end
            S_IDLE, S_DONE:
            begin
                add_sub = 1'b0;
            end
            default:
            begin
                add_sub = 1'b0;
            end
        endcase
    end

    // Sequencer and datapath next state
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        op_next        = op_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        acc_next       = acc_reg;
        result_next    = result_reg;
        neg_q_next     = neg_q_reg;
        neg_r_next     = neg_r_reg;

        // Drop the output valid once the result transfers
        if (out_xfer)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    op_next    = opcode;
                    a_next     = operand_a;
                    b_next     = operand_b;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cnt_next = '0;
                case (op_reg) inside
                    OP_ADD, OP_SUB:
                    begin
                        acc_next   = add_sum[DATA_WIDTH-1:0];
                        state_next = S_DONE;
                    end
                    OP_MUL:
                    begin
                        acc_next   = '0;
                        state_next = S_MUL;
                    end
                    OP_DIV, OP_REM:
                    begin
                        if (b_reg == '0)
                        begin
                            // Divide by zero returns the dividend
                            acc_next   = a_reg;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            neg_q_next = a_reg[DATA_WIDTH-1] ^ b_reg[DATA_WIDTH-1];
                            neg_r_next = a_reg[DATA_WIDTH-1];
                            if (a_reg[DATA_WIDTH-1])
                            begin
                                a_next = add_sum[DATA_WIDTH-1:0];
                            end
                            acc_next   = '0;
                            state_next = S_NEGB;
                        end
                    end
                    default:
                    begin
                        acc_next   = BAD_OPCODE_RESULT;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_NEGB:
            begin
                // Take the divisor magnitude
                if (b_reg[DATA_WIDTH-1])
                begin
                    b_next = add_sum[DATA_WIDTH-1:0];
                end
                state_next = S_DIV;
            end
            S_MUL:
            begin
                // Add the shifted multiplicand when the multiplier bit is set
                if (b_reg[0])
                begin
                    acc_next = add_sum[DATA_WIDTH-1:0];
                end
                a_next   = {a_reg[DATA_WIDTH-2:0], 1'b0};
                b_next   = {1'b0, b_reg[DATA_WIDTH-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = S_DONE;
                end
            end
            S_DIV:
            begin
                // Trial subtract; restore on borrow, shift quotient bit in
                acc_next = add_carry ? add_sum[DATA_WIDTH-1:0] : rem_shift;
                a_next   = {a_reg[DATA_WIDTH-2:0], add_carry};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                // Apply result sign
                if (op_reg == OP_DIV)
                begin
                    acc_next = neg_q_reg ? add_sum[DATA_WIDTH-1:0] : a_reg;
                end
                else
                begin
                    acc_next = neg_r_reg ? add_sum[DATA_WIDTH-1:0] : acc_reg;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // Hand the result to the output register once it is free
                if (out_free)
                begin
                    result_next    = acc_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        acc_reg    <= acc_next;
        result_reg <= result_next;
        neg_q_reg  <= neg_q_next;
        neg_r_reg  <= neg_r_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

`ifndef NO_ASSERTIONS
    // An input transfer always starts the setup step
    a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == S_PREP)
        else $error("input transfer did not start setup");

    // After the last divide step the remainder is below the divisor magnitude
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FIX |-> acc_reg < b_reg)
        else $error("remainder not below divisor");

    // Output valid rises only when a finished result is handed over
    a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("output valid rose outside handoff");

    // A finished result waits while the output register is still occupied
    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && out_valid_reg && out_stall |=> state_reg == S_DONE)
        else $error("finished result left while output was stalled");
`endif

endmodule
